### design/ppc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared widths, register indexes and the controller command type of the
// PID position controller.
// ----------------------------------------------------------------------------
package ppc_pkg;

   // Fixed field and internal widths.
   localparam int ERR_W   = 16;  // error after deadzone and clamp
   localparam int GAIN_W  = 16;
   localparam int LIM_W   = 15;
   localparam int INT_W   = 26;  // integral sum, clamped to 32767*1000
   localparam int DQ_W    = 26;  // derivative numerator after the shift by 8
   localparam int RAW_W   = 27;
   localparam int DRIVE_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_BAND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_LIM  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_LIM  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_POWER  = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the input item
      logic diff;      // form target minus position
      logic limit;     // deadzone and error clamp
      logic mult;      // error products
      logic integ;     // integral update, divider load
      logic imult;     // integral gain product and I clamp
      logic div_step;  // one quotient bit
      logic sum;       // P + I + D
      logic result;    // load the output registers
   } ppc_cmd_type;

endpackage
`default_nettype wire

### design/ppc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_ctrl
// Sequencer that steps the datapath through one update and owns the
// channel handshakes.
// ----------------------------------------------------------------------------
module ppc_ctrl
   import ppc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output ppc_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIFF  = 4'd1;
   localparam logic [3:0] ST_LIMIT = 4'd2;
   localparam logic [3:0] ST_MULT  = 4'd3;
   localparam logic [3:0] ST_INTEG = 4'd4;
   localparam logic [3:0] ST_IMULT = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_SUM   = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   localparam int CNT_W = $clog2(DQ_W);

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            state_in  = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.integ = 1'b1;
            state_in  = ST_IMULT;
         end
         ST_IMULT: begin
            cmd.imult = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DQ_W - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.result = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### design/ppc_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_dpath
// Control registers, loop state and the arithmetic of one update,
// including a restoring divider for the derivative term.
// ----------------------------------------------------------------------------
module ppc_dpath
   import ppc_pkg::*;
#(
   parameter int POS_BITS  = 16,
   parameter int TIME_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ppc_cmd_type           cmd,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic signed [POS_BITS-1:0] req_measured_pos,
   input  wire logic signed [POS_BITS-1:0] req_target_pos,
   input  wire logic [TIME_BITS-1:0]  req_elapsed_ms,
   output logic signed [DRIVE_W-1:0]  rsp_drive,
   output logic signed [RAW_W-1:0]    rsp_raw_power,
   output logic                       rsp_clamped
);

   localparam int DIFF_W = POS_BITS + 1;
   localparam int CW     = (DIFF_W > 16) ? DIFF_W : 16;
   localparam int EP_W   = ERR_W + TIME_BITS + 1;
   localparam int IS_W   = ((EP_W > INT_W) ? EP_W : INT_W) + 1;
   localparam int PP_W   = ERR_W + GAIN_W + 1;
   localparam int DN_W   = ERR_W + 1 + GAIN_W + 1;
   localparam int IP_W   = INT_W + GAIN_W + 1;
   localparam int ILK_W  = 25;

   // Control registers.
   logic [GAIN_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [LIM_W-1:0]  dead_band_ff, error_limit_ff, integ_limit_ff, max_power_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= GAIN_W'(256);
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= '0;
         dead_band_ff   <= '0;
         error_limit_ff <= '1;
         integ_limit_ff <= '1;
         max_power_ff   <= '1;
      end else if (csr_we) begin
         case (csr_index)
            REG_PROP_GAIN:  prop_gain_ff   <= csr_data;
            REG_INTEG_GAIN: integ_gain_ff  <= csr_data;
            REG_DERIV_GAIN: deriv_gain_ff  <= csr_data;
            REG_DEAD_BAND:  dead_band_ff   <= csr_data[LIM_W-1:0];
            REG_ERROR_LIM:  error_limit_ff <= csr_data[LIM_W-1:0];
            REG_INTEG_LIM:  integ_limit_ff <= csr_data[LIM_W-1:0];
            REG_MAX_POWER:  max_power_ff   <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Working registers.
   logic signed [POS_BITS-1:0] pos_ff, tgt_ff;
   logic [TIME_BITS-1:0]       ms_ff;
   logic signed [DIFF_W-1:0]   diff_ff;
   logic signed [ERR_W-1:0]    err_ff, last_err_ff;
   logic signed [EP_W-1:0]     eprod_ff;
   logic signed [PP_W-1:0]     pprod_ff;
   logic signed [DN_W-1:0]     dnum_ff;
   logic signed [INT_W-1:0]    integ_ff;
   logic signed [ERR_W-1:0]    iterm_ff;
   logic [DQ_W-1:0]            quo_ff;
   logic [TIME_BITS-1:0]       rem_ff;
   logic                       dneg_ff;
   logic signed [RAW_W-1:0]    raw_ff;

   // Deadzone and error clamp.
   logic signed [CW-1:0] diff_x, elim_x, err_x;
   logic [CW-1:0]        mag_x;
   always_comb begin
      diff_x = CW'(diff_ff);
      mag_x  = diff_x[CW-1] ? CW'(-diff_x) : CW'(diff_x);
      elim_x = CW'({1'b0, error_limit_ff});
      if (mag_x < CW'(dead_band_ff)) begin
         err_x = '0;
      end else if (diff_x > elim_x) begin
         err_x = elim_x;
      end else if (diff_x < -elim_x) begin
         err_x = -elim_x;
      end else begin
         err_x = diff_x;
      end
   end

   // Integral update clamped at integral_limit*1000; zero error clears it.
   logic [ILK_W-1:0]       ilim_k;
   logic signed [IS_W-1:0] isum, ilk_x, integ_x;
   always_comb begin
      ilim_k = ILK_W'(integ_limit_ff) * ILK_W'(1000);
      ilk_x  = IS_W'($signed({1'b0, ilim_k}));
      isum   = IS_W'(integ_ff) + IS_W'(eprod_ff);
      if (err_ff == '0) begin
         integ_x = '0;
      end else if (isum > ilk_x) begin
         integ_x = ilk_x;
      end else if (isum < -ilk_x) begin
         integ_x = -ilk_x;
      end else begin
         integ_x = isum;
      end
   end

   // Derivative numerator floored by 256, taken apart into sign and magnitude.
   logic signed [DQ_W-1:0] dq;
   logic [DQ_W-1:0]        dq_abs;
   assign dq     = dnum_ff[DN_W-1:8];
   assign dq_abs = dq[DQ_W-1] ? DQ_W'(-dq) : DQ_W'(dq);

   // I term: integral times gain floored by 256, clamped to integral_limit.
   logic signed [IP_W-1:0]   iprod;
   logic signed [IP_W-9:0]   iq;
   logic signed [IP_W-9:0]   ilim_x;
   logic signed [ERR_W-1:0]  iterm_x;
   always_comb begin
      iprod  = integ_ff * $signed({1'b0, integ_gain_ff});
      iq     = iprod[IP_W-1:8];
      ilim_x = (IP_W-8)'($signed({1'b0, integ_limit_ff}));
      if (iq > ilim_x) begin
         iterm_x = ERR_W'(ilim_x);
      end else if (iq < -ilim_x) begin
         iterm_x = ERR_W'(-ilim_x);
      end else begin
         iterm_x = ERR_W'(iq);
      end
   end

   // One restoring divide step.
   logic [TIME_BITS:0] trial;
   logic               fits;
   assign trial = {rem_ff, quo_ff[DQ_W-1]};
   assign fits  = (trial >= {1'b0, ms_ff});

   // D term with floor rounding; zero when no time has elapsed.
   logic signed [RAW_W-1:0] dterm, pterm_x;
   always_comb begin
      if (ms_ff == '0) begin
         dterm = '0;
      end else if (dneg_ff) begin
         if (rem_ff != '0) begin
            dterm = -(RAW_W'(quo_ff) + RAW_W'(1));
         end else begin
            dterm = -RAW_W'(quo_ff);
         end
      end else begin
         dterm = RAW_W'(quo_ff);
      end
      pterm_x = RAW_W'($signed(pprod_ff[PP_W-1:8]));
   end

   // Output clamp and clamp flag.
   logic signed [RAW_W-1:0] plim_x;
   logic signed [RAW_W-1:0] pw_x;
   logic                    over_x;
   always_comb begin
      plim_x = RAW_W'($signed({1'b0, max_power_ff}));
      over_x = (raw_ff > plim_x) || (raw_ff < -plim_x);
      if (raw_ff > plim_x) begin
         pw_x = plim_x;
      end else if (raw_ff < -plim_x) begin
         pw_x = -plim_x;
      end else begin
         pw_x = raw_ff;
      end
   end

   // Loop state.
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else if (cmd.integ) begin
         integ_ff    <= INT_W'(integ_x);
         last_err_ff <= err_ff;
      end
   end

   // Datapath sequence.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff <= req_measured_pos;
         tgt_ff <= req_target_pos;
         ms_ff  <= req_elapsed_ms;
      end
      if (cmd.diff) begin
         diff_ff <= DIFF_W'(tgt_ff) - DIFF_W'(pos_ff);
      end
      if (cmd.limit) begin
         err_ff <= ERR_W'(err_x);
      end
      if (cmd.mult) begin
         eprod_ff <= err_ff * $signed({1'b0, ms_ff});
         pprod_ff <= err_ff * $signed({1'b0, prop_gain_ff});
         dnum_ff  <= (DN_W'(err_ff) - DN_W'(last_err_ff)) * $signed({1'b0, deriv_gain_ff});
      end
      if (cmd.integ) begin
         quo_ff  <= dq_abs;
         rem_ff  <= '0;
         dneg_ff <= dq[DQ_W-1];
      end
      if (cmd.imult) begin
         iterm_ff <= iterm_x;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[DQ_W-2:0], fits};
         rem_ff <= fits ? TIME_BITS'(trial - {1'b0, ms_ff}) : trial[TIME_BITS-1:0];
      end
      if (cmd.sum) begin
         raw_ff <= pterm_x + RAW_W'(iterm_ff) + dterm;
      end
      if (cmd.result) begin
         rsp_drive     <= DRIVE_W'(-pw_x);
         rsp_raw_power <= raw_ff;
         rsp_clamped   <= over_x;
      end
   end

endmodule
`default_nettype wire

### design/pid_position_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_position_controller_core
// PID position controller with deadzone, error clamp, integral anti-windup
// and output clamp; one drive item per position item.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req_     in         measured_pos, target_pos, elapsed_ms
//  rsp_     out        drive, raw_power, clamped
//  csr_     in         index, data (register write)
//
// The restoring divider of the derivative term, one quotient bit per cycle
// over 26 bits, takes most of the time of an item. A new item is accepted
// only once the previous one has reached the output register. Reset is
// synchronous and restores the register defaults and clears the integral
// and last error. A stalled result holds the sequencer before its output
// step.
module pid_position_controller_core
   import ppc_pkg::*;
#(
   parameter int POS_BITS  = 16,
   parameter int TIME_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [POS_BITS-1:0] req_measured_pos,
   input  wire logic signed [POS_BITS-1:0] req_target_pos,
   input  wire logic [TIME_BITS-1:0]       req_elapsed_ms,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [DRIVE_W-1:0]       rsp_drive,
   output logic signed [RAW_W-1:0]         rsp_raw_power,
   output logic                            rsp_clamped,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_data
);

   ppc_cmd_type cmd;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   ppc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ppc_dpath #(
      .POS_BITS  (POS_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_measured_pos (req_measured_pos),
      .req_target_pos   (req_target_pos),
      .req_elapsed_ms   (req_elapsed_ms),
      .rsp_drive        (rsp_drive),
      .rsp_raw_power    (rsp_raw_power),
      .rsp_clamped      (rsp_clamped)
   );

endmodule
`default_nettype wire

### sim/pid_position_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_controller_core_tb
// Self-checking bench for the PID position controller. A behavioral
// controller model predicts drive, raw power and the clamp flag for every
// accepted position item. Results are checked in order under several idle
// and stall patterns and several register settings.
// ----------------------------------------------------------------------------
module pid_position_controller_core_tb;
   import ppc_pkg::*;

   localparam int POS_BITS  = 16;
   localparam int TIME_BITS = 16;

   // One expected controller output.
   typedef struct {
      logic signed [DRIVE_W-1:0] drive;
      logic signed [RAW_W-1:0]   raw_power;
      logic                      clamped;
   } drive_item_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [POS_BITS-1:0] req_measured_pos;
   logic signed [POS_BITS-1:0] req_target_pos;
   logic [TIME_BITS-1:0] req_elapsed_ms;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic signed [RAW_W-1:0] rsp_raw_power;
   logic rsp_clamped;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   pid_position_controller_core #(
      .POS_BITS(POS_BITS),
      .TIME_BITS(TIME_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_measured_pos(req_measured_pos),
      .req_target_pos(req_target_pos),
      .req_elapsed_ms(req_elapsed_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive(rsp_drive),
      .rsp_raw_power(rsp_raw_power),
      .rsp_clamped(rsp_clamped),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Controller registers and state as the model keeps them.
   longint kp, ki, kd, band, err_lim, int_lim, pwr_lim;
   longint integ_acc, prev_err;

   drive_item_type expected_drives[$];
   int errors;
   int send_idle_pct;
   int recv_stall_pct;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit.
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic longint clip(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   // Division rounding toward minus infinity; d is positive.
   function automatic longint floor_div(longint n, longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic void reset_controller();
      kp = 256; ki = 0; kd = 0; band = 0;
      err_lim = 32767; int_lim = 32767; pwr_lim = 32767;
      integ_acc = 0; prev_err = 0;
   endfunction

   function automatic void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         REG_PROP_GAIN: kp = d;
         REG_INTEG_GAIN: ki = d;
         REG_DERIV_GAIN: kd = d;
         REG_DEAD_BAND: band = d[14:0];
         REG_ERROR_LIM: err_lim = d[14:0];
         REG_INTEG_LIM: int_lim = d[14:0];
         REG_MAX_POWER: pwr_lim = d[14:0];
         default: ;
      endcase
   endfunction

   // Works out the drive for one position item and advances the state.
   function automatic drive_item_type predict_drive(logic signed [POS_BITS-1:0] pos,
                                                    logic signed [POS_BITS-1:0] tgt,
                                                    logic [TIME_BITS-1:0] ms_in);
      drive_item_type r;
      longint err, mag, ms, p, i, d, raw, pw;
      ms = ms_in;
      err = longint'(tgt) - longint'(pos);
      mag = err < 0 ? -err : err;
      if (mag < band) err = 0;
      err = clip(err, err_lim);
      if (err != 0) integ_acc = clip(integ_acc + err * ms, int_lim * 1000);
      else integ_acc = 0;
      p = floor_div(err * kp, 256);
      i = clip(floor_div(integ_acc * ki, 256), int_lim);
      d = (ms != 0) ? floor_div((err - prev_err) * kd, 256 * ms) : 0;
      prev_err = err;
      raw = p + i + d;
      pw = clip(raw, pwr_lim);
      r.drive = DRIVE_W'(-pw);
      r.raw_power = RAW_W'(raw);
      r.clamped = (raw > pwr_lim || raw < -pwr_lim);
      return r;
   endfunction

   // Sends one position item and records its expected drive.
   task automatic send_position(logic signed [POS_BITS-1:0] pos,
                                logic signed [POS_BITS-1:0] tgt,
                                logic [TIME_BITS-1:0] ms);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_measured_pos <= pos;
      req_target_pos <= tgt;
      req_elapsed_ms <= ms;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_drives.push_back(predict_drive(pos, tgt, ms));
      @(negedge clock);
      req_valid <= 1'b0;
      // The block stays busy on the accepted item, so the extra gap costs nothing.
      @(negedge clock);
   endtask

   // Writes one register once csr_ready is high and updates the model.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_index <= idx;
      csr_data <= d;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      write_register(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (expected_drives.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drives.size() == 0) begin
            $error("unexpected drive item");
            errors++;
         end else begin
            drive_item_type e;
            e = expected_drives.pop_front();
            if (rsp_drive !== e.drive) begin
               $error("drive: expected %0d, got %0d", e.drive, rsp_drive);
               errors++;
            end
            if (rsp_raw_power !== e.raw_power) begin
               $error("raw_power: expected %0d, got %0d", e.raw_power, rsp_raw_power);
               errors++;
            end
            if (rsp_clamped !== e.clamped) begin
               $error("clamped: expected %0d, got %0d", e.clamped, rsp_clamped);
               errors++;
            end
         end
      end
   end

   // Receiver stalls.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [POS_BITS-1:0] rand_pos();
      case ($urandom_range(3))
         0: return POS_BITS'(32'h7fff - $urandom_range(3));
         1: return POS_BITS'(32'h8000 + $urandom_range(3));
         2: return POS_BITS'($urandom());
         default: return POS_BITS'($urandom_range(400) - 200);
      endcase
   endfunction

   function automatic logic [TIME_BITS-1:0] rand_ms();
      case ($urandom_range(3))
         0: return '0;
         1: return TIME_BITS'($urandom());
         default: return TIME_BITS'($urandom_range(20));
      endcase
   endfunction

   // Corner items under reset register values and extreme settings.
   task automatic test_directed();
      send_position(16'sh8000, 16'sh7fff, 16'hffff);
      send_position(16'sh7fff, 16'sh8000, 16'hffff);
      send_position(0, 0, 0);
      send_position(0, 100, 0);
      send_position(10, -10, 1);
      wait_idle();
      write_csr(REG_PROP_GAIN, 16'hffff);
      write_csr(REG_INTEG_GAIN, 16'hffff);
      write_csr(REG_DERIV_GAIN, 16'hffff);
      write_csr(REG_DEAD_BAND, 16'd5);
      send_position(0, 4, 3);
      send_position(0, -5, 3);
      send_position(16'sh8000, 16'sh7fff, 16'hffff);
      send_position(16'sh7fff, 16'sh8000, 1);
      send_position(16'sh7fff, 16'sh8000, 0);
      send_position(0, 0, 7);
      wait_idle();
      write_csr(REG_ERROR_LIM, 16'd0);
      write_csr(REG_MAX_POWER, 16'd0);
      write_csr(3'd7, 16'hffff);
      send_position(0, 1000, 5);
      wait_idle();
      write_csr(REG_ERROR_LIM, 16'hffff);
      write_csr(REG_INTEG_LIM, 16'd0);
      write_csr(REG_MAX_POWER, 16'hffff);
      send_position(-300, 300, 9);
      send_position(16'sh8000, 16'sh7fff, 100);
      wait_idle();
   endtask

   // Random register settings followed by random position items.
   task automatic test_random(int n, int sidle, int rstall);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_idle();
      write_csr(REG_PROP_GAIN, CSR_DATA_W'($urandom()));
      write_csr(REG_INTEG_GAIN, ($urandom_range(3) == 0) ? 16'hffff :
                CSR_DATA_W'($urandom_range(64)));
      write_csr(REG_DERIV_GAIN, CSR_DATA_W'($urandom()));
      write_csr(REG_DEAD_BAND, ($urandom_range(1) != 0) ? CSR_DATA_W'($urandom_range(20)) :
                CSR_DATA_W'($urandom()));
      write_csr(REG_ERROR_LIM, ($urandom_range(1) != 0) ? 16'h7fff : CSR_DATA_W'($urandom()));
      write_csr(REG_INTEG_LIM, CSR_DATA_W'($urandom()));
      write_csr(REG_MAX_POWER, ($urandom_range(1) != 0) ? 16'h7fff : CSR_DATA_W'($urandom()));
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      for (int k = 0; k < n; k++) begin
         send_position(rand_pos(), rand_pos(), rand_ms());
         // Hold off once until all expected drives have come out.
         if (k == n / 2) wait_idle();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_idle();
   endtask

   initial begin
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_measured_pos = '0;
      req_target_pos = '0;
      req_elapsed_ms = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset_controller();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(260, 0, 0);
      test_random(260, 78, 0);
      test_random(260, 0, 78);
      test_random(260, 27, 27);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
